/* rtl/pcld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcld_pkg
// Types, codes and helper functions shared by the patch code line decoder.
// ----------------------------------------------------------------------------
package pcld_pkg;

	// line kinds
	localparam logic [1:0] OP_CODE    = 2'd0;
	localparam logic [1:0] OP_SECTION = 2'd1;
	localparam logic [1:0] OP_END     = 2'd2;

	// result status codes
	localparam logic [2:0] ST_RECORD     = 3'd0;
	localparam logic [2:0] ST_MORE       = 3'd1;
	localparam logic [2:0] ST_IGNORED    = 3'd2;
	localparam logic [2:0] ST_SYNTAX_ERR = 3'd3;
	localparam logic [2:0] ST_INCOMPLETE = 3'd4;
	localparam logic [2:0] ST_END_OK     = 3'd5;

	// record kinds
	localparam logic [2:0] K_WRITE      = 3'd0;
	localparam logic [2:0] K_SECT_WRITE = 3'd1;
	localparam logic [2:0] K_ADD        = 3'd2;
	localparam logic [2:0] K_LOOP       = 3'd3;
	localparam logic [2:0] K_SEARCH     = 3'd4;
	localparam logic [2:0] K_OFFSET_DEC = 3'd5;
	localparam logic [2:0] K_SECT_OFS   = 3'd6;

	// leading hex digit routing
	localparam logic [3:0] D0_LOOP   = 4'h4;
	localparam logic [3:0] D0_ADD    = 4'h7;
	localparam logic [3:0] D0_SEARCH = 4'h8;
	localparam logic [3:0] D0_OFFSET = 4'h9;
	localparam logic [3:0] DIGIT_REL = 4'h8;
	localparam logic [3:0] D1_OFFSET = 4'h3;
	localparam logic [3:0] MAX_SIZE  = 4'h2;

	// decoder phase
	typedef enum logic [2:0] {
		PH_CODE   = 3'b001,
		PH_LOOP   = 3'b010,
		PH_SEARCH = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        special_mark;
		logic [31:0] address_word;
		logic [31:0] value_word;
		logic [30:0] section_number;
	} line_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  record_kind;
		logic [23:0] target_address;
		logic [31:0] data_value;
		logic [31:0] data_step;
		logic [2:0]  access_size;
		logic        offset_relative;
		logic [30:0] section_id;
		logic [11:0] repeat_count;
		logic [15:0] address_step;
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_count;
	} rec_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [23:0] loop_addr;
		logic [11:0] loop_count;
		logic [15:0] loop_astep;
		logic [1:0]  loop_size;
		logic        loop_rel;
		logic [11:0] search_count;
		logic [15:0] bytes_left;
	} dec_state_t;

	// keep the low n bytes of a word, n up to 4
	function automatic logic [31:0] byte_mask32(input logic [2:0] n);
		logic [31:0] m;
		case (n)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00FF;
			3'd2: m = 32'h0000_FFFF;
			3'd3: m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// size code to bytes per access
	function automatic logic [2:0] size_bytes(input logic [3:0] code);
		logic [2:0] b;
		case (code)
			4'd0: b = 3'd1;
			4'd1: b = 3'd2;
			default: b = 3'd4;
		endcase
		return b;
	endfunction

endpackage

/* rtl/pcld_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcld_decode
// Single-pass decode of one patch line against the held loop/search state:
// produces the result record and the state left behind.
// ----------------------------------------------------------------------------
module pcld_decode import pcld_pkg::*; (
	input  line_item_t line_data,
	input  dec_state_t cur_state,
	output rec_item_t  rec_data,
	output dec_state_t nxt_state
);

	logic [3:0]  d0, d1, d2;
	logic [23:0] a24;
	logic [31:0] aw, vw;
	logic        rel;
	logic        ph_loop, ph_search, ph_busy;
	logic [15:0] r1;
	logic [2:0]  n1, n2, n0;
	logic [15:0] r_next;
	logic        s_done;
	logic [15:0] total;

	assign aw  = line_data.address_word;
	assign vw  = line_data.value_word;
	assign d0  = aw[31:28];
	assign d1  = aw[27:24];
	assign d2  = aw[23:20];
	assign a24 = aw[23:0];
	assign rel = (d1 == DIGIT_REL);

	// phase decode, unused codes act as expecting a code line
	always_comb begin
		ph_loop   = 1'b0;
		ph_search = 1'b0;
		case (cur_state.phase)
			PH_LOOP:   ph_loop = 1'b1;
			PH_SEARCH: ph_search = 1'b1;
			default:   ph_loop = 1'b0;
		endcase
	end
	assign ph_busy = ph_loop | ph_search;

	// search continuation: up to two 4-byte chunks per line
	assign r1 = cur_state.bytes_left - 16'd4;
	always_comb begin
		n1     = 3'd4;
		n2     = 3'd0;
		r_next = 16'd0;
		s_done = 1'b1;
		if (cur_state.bytes_left <= 16'd4) begin
			n1 = cur_state.bytes_left[2:0];
		end else if (r1 <= 16'd4) begin
			n2 = r1[2:0];
		end else begin
			n2     = 3'd4;
			r_next = r1 - 16'd4;
			s_done = 1'b0;
		end
	end

	// first search line: byte total and first chunk length
	assign total = aw[15:0];
	assign n0    = (total < 16'd4) ? total[2:0] : 3'd4;

	// main routing
	always_comb begin
		rec_data  = '0;
		nxt_state = cur_state;
		case (line_data.op)
			OP_END: begin
				rec_data.status = ph_busy ? ST_INCOMPLETE : ST_END_OK;
				nxt_state.phase = PH_CODE;
			end
			OP_SECTION: begin
				if (ph_busy) begin
					rec_data.status = ST_SYNTAX_ERR;
					nxt_state.phase = PH_CODE;
				end else begin
					rec_data.record_kind     = K_SECT_OFS;
					rec_data.offset_relative = 1'b1;
					rec_data.section_id      = line_data.section_number;
				end
			end
			OP_CODE: begin
				if (line_data.special_mark && ph_busy) begin
					rec_data.status = ST_SYNTAX_ERR;
					nxt_state.phase = PH_CODE;
				end else if (ph_loop) begin
					// second loop line
					rec_data.record_kind     = K_LOOP;
					rec_data.target_address  = cur_state.loop_addr;
					rec_data.data_value      = aw;
					rec_data.data_step       = vw;
					rec_data.access_size     = {1'b0, cur_state.loop_size};
					rec_data.offset_relative = cur_state.loop_rel;
					rec_data.repeat_count    = cur_state.loop_count;
					rec_data.address_step    = cur_state.loop_astep;
					nxt_state.phase          = PH_CODE;
				end else if (ph_search) begin
					// search pattern continuation
					rec_data.record_kind   = K_SEARCH;
					rec_data.repeat_count  = cur_state.search_count;
					rec_data.pattern_bytes = {vw & byte_mask32(n2), aw & byte_mask32(n1)};
					rec_data.pattern_count = {1'b0, n1} + {1'b0, n2};
					nxt_state.bytes_left   = r_next;
					if (s_done) begin
						rec_data.target_address  = a24;
						rec_data.data_value      = vw;
						rec_data.offset_relative = rel;
						nxt_state.phase          = PH_CODE;
					end else begin
						rec_data.status = ST_MORE;
					end
				end else if (line_data.special_mark) begin
					// section write
					if (d0 > MAX_SIZE) begin
						rec_data.status = ST_SYNTAX_ERR;
					end else begin
						rec_data.record_kind     = K_SECT_WRITE;
						rec_data.target_address  = {4'h0, a24[19:0]};
						rec_data.data_value      = vw;
						rec_data.offset_relative = rel;
						rec_data.access_size     = size_bytes(d0);
						rec_data.section_id      = {23'd0, aw[27:20]};
					end
				end else begin
					case (d0)
						4'h0, 4'h1, 4'h2: begin
							rec_data.record_kind     = K_WRITE;
							rec_data.target_address  = a24;
							rec_data.data_value      = vw;
							rec_data.offset_relative = rel;
							rec_data.access_size     = size_bytes(d0);
						end
						D0_LOOP: begin
							if (vw[31:28] > MAX_SIZE) begin
								rec_data.status = ST_SYNTAX_ERR;
							end else begin
								nxt_state.loop_rel   = rel;
								nxt_state.loop_addr  = a24;
								nxt_state.loop_count = vw[27:16];
								nxt_state.loop_astep = vw[15:0];
								nxt_state.loop_size  = vw[29:28];
								nxt_state.phase      = PH_LOOP;
								rec_data.status          = ST_MORE;
								rec_data.record_kind     = K_LOOP;
								rec_data.target_address  = a24;
								rec_data.access_size     = {1'b0, vw[29:28]};
								rec_data.offset_relative = rel;
								rec_data.repeat_count    = vw[27:16];
								rec_data.address_step    = vw[15:0];
							end
						end
						D0_ADD: begin
							if (d1 > MAX_SIZE) begin
								rec_data.status = ST_IGNORED;
							end else begin
								rec_data.record_kind     = K_ADD;
								rec_data.target_address  = {4'h0, a24[19:0]};
								rec_data.data_value      = vw;
								rec_data.offset_relative = (d2 == DIGIT_REL);
								rec_data.access_size     = size_bytes(d1);
							end
						end
						D0_SEARCH: begin
							nxt_state.search_count = aw[27:16];
							rec_data.record_kind   = K_SEARCH;
							rec_data.repeat_count  = aw[27:16];
							rec_data.pattern_bytes = {32'd0, vw & byte_mask32(n0)};
							rec_data.pattern_count = {1'b0, n0};
							if (total > 16'd4) begin
								nxt_state.bytes_left = total - 16'd4;
								nxt_state.phase      = PH_SEARCH;
								rec_data.status      = ST_MORE;
							end else begin
								rec_data.target_address  = a24;
								rec_data.data_value      = vw;
								rec_data.offset_relative = rel;
							end
						end
						D0_OFFSET: begin
							if (d1 != D1_OFFSET) begin
								rec_data.status = ST_SYNTAX_ERR;
							end else begin
								rec_data.record_kind    = K_OFFSET_DEC;
								rec_data.target_address = a24;
								rec_data.data_value     = vw;
							end
						end
						default: begin
							rec_data.status = ST_SYNTAX_ERR;
						end
					endcase
				end
			end
			default: begin
				rec_data.status = ST_IGNORED;
			end
		endcase
	end

endmodule

/* rtl/patch_code_line_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_code_line_decoder
// Turns memory-patch code lines into patch records, one record per line.
// ----------------------------------------------------------------------------
// Each request (a code line, a section line or an end mark) yields exactly one
// record. A request is captured in an input register, decoded against the held
// loop/search state, and placed in an output register; the held state updates
// in the same cycle the record is loaded. The block takes one line per cycle
// while the output is not stalled; an accepted line passes the input register
// and then the output register, where its record waits until taken. A stalled
// output holds the record while one more line waits in the input register.
// Loops span two lines, searches as many lines as their pattern needs; errors
// and the end mark return the decoder to expecting a fresh code line.
module patch_code_line_decoder import pcld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_valid,
	output logic       line_ready,
	input  line_item_t line_data,
	output logic       rec_valid,
	input  logic       rec_ready,
	output rec_item_t  rec_data
);

	logic       valid_s1;
	line_item_t line_s1;
	logic       valid_s2;
	rec_item_t  rec_s2;
	dec_state_t state_q;
	dec_state_t state_nxt;
	rec_item_t  rec_nxt;
	logic       advance;
	logic       load_s2;

	// output stage free or emptying this cycle
	assign advance    = !valid_s2 || rec_ready;
	assign load_s2    = valid_s1 && advance;
	assign line_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_ready) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_valid && line_ready) begin
			line_s1 <= line_data;
		end
	end

	// line decode
	pcld_decode u_decode (
		.line_data (line_s1),
		.cur_state (state_q),
		.rec_data  (rec_nxt),
		.nxt_state (state_nxt)
	);

	// held loop/search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_CODE, loop_addr: '0, loop_count: '0, loop_astep: '0,
				loop_size: '0, loop_rel: 1'b0, search_count: '0, bytes_left: '0};
		end else if (load_s2) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			rec_s2 <= rec_nxt;
		end
	end

	assign rec_valid = valid_s2;
	assign rec_data  = rec_s2;

	// an empty output stage never holds back the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> line_ready)
		else $error("line_ready low with empty output stage");

	// a first loop line leaves the decoder waiting for the second line
	a_loop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && rec_nxt.status == ST_MORE && rec_nxt.record_kind == K_LOOP)
		|=> state_q.phase == PH_LOOP)
		else $error("loop first line did not enter loop phase");

	// a pending record implies a pending loop or search
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rec_s2.status == ST_MORE) |-> state_q.phase != PH_CODE)
		else $error("more-lines record while expecting a code line");

	// pattern chunks never exceed eight bytes
	a_pattern_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rec_s2.pattern_count <= 4'd8)
		else $error("pattern count above eight");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the patch code line decoder. A short table of
// directed lines covers every line kind, the field extremes and each error
// path. About 1500 random lines follow, shaped by what the decoder waits for.
// Every record is compared field by field against a line-level predictor
// that keeps its own loop and search state, or against a bare status where
// a directed row fixes one. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import pcld_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_LINES = 1500;
	localparam int QUIET_TAIL   = 200;

	// one directed row: the line and, where obvious, the bare status it must give
	typedef struct {
		line_item_t ln;
		bit         fixed;
		logic [2:0] fixed_status;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       line_valid = 1'b0;
	logic       line_ready;
	line_item_t line_data = '0;
	logic       rec_valid;
	logic       rec_ready = 1'b0;
	rec_item_t  rec_data;

	// predictor state
	phase_t      cur_phase = PH_CODE;
	logic [23:0] pend_loop_addr = '0;
	logic [11:0] pend_loop_count = '0;
	logic [15:0] pend_loop_astep = '0;
	logic [1:0]  pend_loop_size = '0;
	logic        pend_loop_rel = 1'b0;
	logic [11:0] pend_search_count = '0;
	logic [15:0] pend_bytes_left = '0;

	rec_item_t expected_records[$];
	int        error_count = 0;
	int        records_seen = 0;
	int        status_seen[8];
	int        line_gap_pct = 0;
	int        rec_stall_pct = 0;
	int        rec_stall_left = 0;
	bit        quiet = 1'b0;

	patch_code_line_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (line_valid),
		.line_ready (line_ready),
		.line_data  (line_data),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready),
		.rec_data   (rec_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		#2000000;
		$display("timeout with %0d records outstanding", expected_records.size());
		$display("simulation failed");
		$finish;
	end

	// keep the low n bytes of a word
	function automatic logic [31:0] low_bytes(input logic [31:0] w, input int n);
		return (n >= 4) ? w : (w & ((32'd1 << (8 * n)) - 32'd1));
	endfunction

	// size digit to bytes per access
	function automatic logic [2:0] access_bytes(input logic [3:0] code);
		return (code == 4'd0) ? 3'd1 : ((code == 4'd1) ? 3'd2 : 3'd4);
	endfunction

	function automatic line_item_t mk_line(input logic [1:0] op, input logic sp,
			input logic [31:0] aw, input logic [31:0] vw, input logic [30:0] sect);
		line_item_t l;
		l.op = op;
		l.special_mark = sp;
		l.address_word = aw;
		l.value_word = vw;
		l.section_number = sect;
		return l;
	endfunction

	function automatic stim_row_t drow(input logic [1:0] op, input logic sp,
			input logic [31:0] aw, input logic [31:0] vw, input logic [30:0] sect,
			input bit fixed, input logic [2:0] st);
		stim_row_t r;
		r.ln = mk_line(op, sp, aw, vw, sect);
		r.fixed = fixed;
		r.fixed_status = st;
		return r;
	endfunction

	// decode one line into its record and advance the held loop/search state
	task automatic decode_line(input line_item_t ln, output rec_item_t r);
		logic [31:0] aw;
		logic [31:0] vw;
		logic [3:0]  d0;
		logic [3:0]  d1;
		logic [3:0]  d2;
		logic        rel;
		logic [3:0]  sz;
		int          left;
		int          n1;
		int          n2;
		int          total;
		bit          done;
		aw = ln.address_word;
		vw = ln.value_word;
		d0 = aw[31:28];
		d1 = aw[27:24];
		d2 = aw[23:20];
		rel = (d1 == DIGIT_REL);
		r = '0;
		case (ln.op)
			OP_END: begin
				r.status = (cur_phase != PH_CODE) ? ST_INCOMPLETE : ST_END_OK;
				cur_phase = PH_CODE;
			end
			OP_SECTION: begin
				if (cur_phase != PH_CODE) begin
					r.status = ST_SYNTAX_ERR;
					cur_phase = PH_CODE;
				end else begin
					r.record_kind = K_SECT_OFS;
					r.offset_relative = 1'b1;
					r.section_id = ln.section_number;
				end
			end
			OP_CODE: begin
				if (ln.special_mark && cur_phase != PH_CODE) begin
					r.status = ST_SYNTAX_ERR;
					cur_phase = PH_CODE;
				end else if (cur_phase == PH_LOOP) begin
					// second loop line supplies data start and data step
					r.record_kind = K_LOOP;
					r.target_address = pend_loop_addr;
					r.data_value = aw;
					r.data_step = vw;
					r.access_size = 3'(pend_loop_size);
					r.offset_relative = pend_loop_rel;
					r.repeat_count = pend_loop_count;
					r.address_step = pend_loop_astep;
					cur_phase = PH_CODE;
				end else if (cur_phase == PH_SEARCH) begin
					// continuation: up to 4 bytes from each word
					left = int'(pend_bytes_left);
					n2 = 0;
					if (left <= 4) begin
						n1 = left;
						left = 0;
						done = 1'b1;
					end else begin
						n1 = 4;
						left -= 4;
						if (left <= 4) begin
							n2 = left;
							left = 0;
							done = 1'b1;
						end else begin
							n2 = 4;
							left -= 4;
							done = 1'b0;
						end
					end
					r.pattern_bytes = {low_bytes(vw, n2), low_bytes(aw, n1)};
					r.pattern_count = 4'(n1 + n2);
					r.record_kind = K_SEARCH;
					r.repeat_count = pend_search_count;
					pend_bytes_left = 16'(left);
					if (!done) begin
						r.status = ST_MORE;
					end else begin
						r.target_address = aw[23:0];
						r.data_value = vw;
						r.offset_relative = rel;
						cur_phase = PH_CODE;
					end
				end else if (ln.special_mark) begin
					// section write
					if (d0 > MAX_SIZE) begin
						r.status = ST_SYNTAX_ERR;
					end else begin
						r.record_kind = K_SECT_WRITE;
						r.target_address = {4'h0, aw[19:0]};
						r.data_value = vw;
						r.offset_relative = rel;
						r.access_size = access_bytes(d0);
						r.section_id = 31'(aw[27:20]);
					end
				end else if (d0 <= MAX_SIZE) begin
					r.record_kind = K_WRITE;
					r.target_address = aw[23:0];
					r.data_value = vw;
					r.offset_relative = rel;
					r.access_size = access_bytes(d0);
				end else begin
					case (d0)
						D0_LOOP: begin
							sz = vw[31:28];
							if (sz > MAX_SIZE) begin
								r.status = ST_SYNTAX_ERR;
							end else begin
								pend_loop_rel = rel;
								pend_loop_addr = aw[23:0];
								pend_loop_count = vw[27:16];
								pend_loop_astep = vw[15:0];
								pend_loop_size = sz[1:0];
								cur_phase = PH_LOOP;
								r.status = ST_MORE;
								r.record_kind = K_LOOP;
								r.target_address = aw[23:0];
								r.access_size = 3'(sz);
								r.offset_relative = rel;
								r.repeat_count = vw[27:16];
								r.address_step = vw[15:0];
							end
						end
						D0_ADD: begin
							if (d1 > MAX_SIZE) begin
								r.status = ST_IGNORED;
							end else begin
								r.record_kind = K_ADD;
								r.target_address = {4'h0, aw[19:0]};
								r.data_value = vw;
								r.offset_relative = (d2 == DIGIT_REL);
								r.access_size = access_bytes(d1);
							end
						end
						D0_SEARCH: begin
							total = int'(aw[15:0]);
							n1 = (total < 4) ? total : 4;
							pend_search_count = aw[27:16];
							r.record_kind = K_SEARCH;
							r.repeat_count = aw[27:16];
							r.pattern_bytes = {32'h0, low_bytes(vw, n1)};
							r.pattern_count = 4'(n1);
							if (total > 4) begin
								pend_bytes_left = 16'(total - 4);
								cur_phase = PH_SEARCH;
								r.status = ST_MORE;
							end else begin
								r.target_address = aw[23:0];
								r.data_value = vw;
								r.offset_relative = rel;
							end
						end
						D0_OFFSET: begin
							if (d1 != D1_OFFSET) begin
								r.status = ST_SYNTAX_ERR;
							end else begin
								r.record_kind = K_OFFSET_DEC;
								r.target_address = aw[23:0];
								r.data_value = vw;
							end
						end
						default: begin
							r.status = ST_SYNTAX_ERR;
						end
					endcase
				end
			end
			default: begin
				r.status = ST_IGNORED;
			end
		endcase
	endtask

	// random line, shaped by what the decoder is waiting for
	task automatic make_random_line(output line_item_t ln);
		int pick;
		pick = $urandom_range(0, 99);
		ln.op = OP_CODE;
		ln.special_mark = 1'b0;
		ln.address_word = $urandom;
		ln.value_word = $urandom;
		ln.section_number = 31'($urandom);
		if (cur_phase == PH_LOOP) begin
			pick = (pick < 85) ? -1 : 100;
		end else if (cur_phase == PH_SEARCH) begin
			pick = (pick < 90) ? -1 : 100;
		end
		if (pick < 0) begin
			// well-formed continuation line, random content
		end else if (pick < 24) begin
			ln.address_word[31:28] = 4'($urandom_range(0, 2));
			if ($urandom_range(0, 1)) ln.address_word[27:24] = DIGIT_REL;
		end else if (pick < 34) begin
			ln.special_mark = 1'b1;
			ln.address_word[31:28] = ($urandom_range(0, 9) < 8) ?
				4'($urandom_range(0, 2)) : 4'($urandom_range(3, 15));
		end else if (pick < 46) begin
			ln.address_word[31:28] = D0_LOOP;
			if ($urandom_range(0, 1)) ln.address_word[27:24] = DIGIT_REL;
			ln.value_word[31:28] = ($urandom_range(0, 9) == 0) ?
				4'($urandom_range(3, 15)) : 4'($urandom_range(0, 2));
		end else if (pick < 60) begin
			ln.address_word[31:28] = D0_SEARCH;
			if ($urandom_range(0, 1)) ln.address_word[27:24] = DIGIT_REL;
			ln.address_word[15:0] = ($urandom_range(0, 9) == 0) ?
				16'($urandom_range(0, 600)) : 16'($urandom_range(0, 40));
		end else if (pick < 68) begin
			ln.address_word[31:28] = D0_ADD;
			if ($urandom_range(0, 5) != 0) ln.address_word[27:24] = 4'($urandom_range(0, 2));
			if ($urandom_range(0, 1)) ln.address_word[23:20] = DIGIT_REL;
		end else if (pick < 74) begin
			ln.address_word[31:28] = D0_OFFSET;
			if ($urandom_range(0, 5) != 0) ln.address_word[27:24] = D1_OFFSET;
		end else if (pick < 80) begin
			ln.op = OP_SECTION;
			ln.special_mark = 1'($urandom_range(0, 1));
		end else if (pick < 84) begin
			ln.op = OP_END;
		end else begin
			// noise: any line kind, any mark, any words
			ln.op = 2'($urandom_range(0, 3));
			ln.special_mark = 1'($urandom_range(0, 1));
		end
	endtask

	// present one request and wait for it to be taken
	task automatic send_line(input line_item_t ln, input bit fixed, input logic [2:0] st);
		rec_item_t want;
		if (!quiet && $urandom_range(0, 99) < line_gap_pct) begin
			line_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		decode_line(ln, want);
		if (fixed) begin
			want = '0;
			want.status = st;
		end
		expected_records.push_back(want);
		line_valid <= 1'b1;
		line_data <= ln;
		@(posedge clk);
		while (!line_ready) @(posedge clk);
	endtask

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns, record %0d: %s", $time, records_seen, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// record side back-pressure in bursts
	always @(posedge clk) begin
		if (rec_stall_left > 0) begin
			rec_stall_left--;
			rec_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < rec_stall_pct) begin
			rec_stall_left = $urandom_range(1, 18) - 1;
			rec_ready <= 1'b0;
		end else begin
			rec_ready <= 1'b1;
		end
	end

	// compare each record with the oldest expectation
	always @(posedge clk) begin
		rec_item_t want;
		if (arst_n && rec_valid && rec_ready) begin
			status_seen[rec_data.status]++;
			if (expected_records.size() == 0) begin
				flag_error($sformatf("record with no line pending, status %0d", rec_data.status));
			end else begin
				want = expected_records.pop_front();
				check_field("status", 64'(rec_data.status), 64'(want.status));
				check_field("record_kind", 64'(rec_data.record_kind),
					64'(want.record_kind));
				check_field("target_address", 64'(rec_data.target_address),
					64'(want.target_address));
				check_field("data_value", 64'(rec_data.data_value), 64'(want.data_value));
				check_field("data_step", 64'(rec_data.data_step), 64'(want.data_step));
				check_field("access_size", 64'(rec_data.access_size),
					64'(want.access_size));
				check_field("offset_relative", 64'(rec_data.offset_relative),
					64'(want.offset_relative));
				check_field("section_id", 64'(rec_data.section_id), 64'(want.section_id));
				check_field("repeat_count", 64'(rec_data.repeat_count),
					64'(want.repeat_count));
				check_field("address_step", 64'(rec_data.address_step),
					64'(want.address_step));
				check_field("pattern_bytes", rec_data.pattern_bytes, want.pattern_bytes);
				check_field("pattern_count", 64'(rec_data.pattern_count),
					64'(want.pattern_count));
			end
			records_seen++;
		end
	end

	// main sequence
	initial begin
		stim_row_t  dir_rows[];
		line_item_t ln;
		int         lines_sent;
		dir_rows = '{
			// end mark straight after reset
			drow(OP_END, 1'b0, 32'h0000_0000, 32'h0000_0000, 31'h0, 1'b1, ST_END_OK),
			// plain writes: byte, halfword relative, word at the extremes
			drow(OP_CODE, 1'b0, 32'h0000_0000, 32'h0000_0000, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h1812_3456, 32'hDEAD_BEEF, 31'h7FFF_FFFF, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h2FFF_FFFF, 32'hFFFF_FFFF, 31'h0, 1'b0, ST_RECORD),
			// a section write, then a bad size digit
			drow(OP_CODE, 1'b1, 32'h0FFF_FFFF, 32'h1234_5678, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b1, 32'h3000_0000, 32'h0000_0000, 31'h0, 1'b1, ST_SYNTAX_ERR),
			// add relative by digit 2, then an add with size too large
			drow(OP_CODE, 1'b0, 32'h7281_2345, 32'h8000_0001, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h7300_0000, 32'h0000_0000, 31'h0, 1'b1, ST_IGNORED),
			// offset decrement, bad offset digit, unknown leading digit
			drow(OP_CODE, 1'b0, 32'h9300_0010, 32'hFFFF_FFFF, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h9400_0000, 32'h0000_0000, 31'h0, 1'b1, ST_SYNTAX_ERR),
			drow(OP_CODE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0, 1'b1, ST_SYNTAX_ERR),
			// section line, at-mark ignored
			drow(OP_SECTION, 1'b1, 32'hFFFF_FFFF, 32'h0, 31'h7FFF_FFFF, 1'b0, ST_RECORD),
			// full loop with extreme fields
			drow(OP_CODE, 1'b0, 32'h48FF_FFFF, 32'h2FFF_FFFF, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 31'h0, 1'b0, ST_RECORD),
			// loop with bad size code
			drow(OP_CODE, 1'b0, 32'h4000_0000, 32'h3000_0000, 31'h0, 1'b1, ST_SYNTAX_ERR),
			// loop broken by a section line, then by an at-mark line
			drow(OP_CODE, 1'b0, 32'h4000_0010, 32'h0001_0004, 31'h0, 1'b0, ST_RECORD),
			drow(OP_SECTION, 1'b0, 32'h0, 32'h0, 31'h5, 1'b1, ST_SYNTAX_ERR),
			drow(OP_CODE, 1'b0, 32'h4100_0000, 32'h1002_0002, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b1, 32'h0000_0000, 32'h0, 31'h0, 1'b1, ST_SYNTAX_ERR),
			// empty search; then a search of 0xF00D bytes, still open after three lines
			drow(OP_CODE, 1'b0, 32'h8000_0000, 32'hAABB_CCDD, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h88FF_F00D, 32'h4433_2211, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h8877_6655, 32'hCCBB_AA99, 31'h0, 1'b0, ST_RECORD),
			drow(OP_CODE, 1'b0, 32'h0012_34EE, 32'h5566_7788, 31'h0, 1'b0, ST_RECORD),
			// search left open at the end mark
			drow(OP_CODE, 1'b0, 32'h8000_0006, 32'h1122_3344, 31'h0, 1'b0, ST_RECORD),
			drow(OP_END, 1'b0, 32'h0, 32'h0, 31'h0, 1'b1, ST_INCOMPLETE),
			// unused line kind
			drow(OP_UNUSED, 1'b0, 32'h0, 32'h0, 31'h0, 1'b1, ST_IGNORED)
		};

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		line_gap_pct = 20;
		rec_stall_pct = 20;
		foreach (dir_rows[i]) send_line(dir_rows[i].ln, dir_rows[i].fixed,
			dir_rows[i].fixed_status);

		// random lines, idling mix changes every 150 lines, quiet at the tail
		for (lines_sent = 0; lines_sent < RANDOM_LINES; lines_sent++) begin
			if (lines_sent % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						line_gap_pct = 0;
						rec_stall_pct = 0;
					end
					1: begin
						line_gap_pct = 10;
						rec_stall_pct = 40;
					end
					default: begin
						line_gap_pct = 40;
						rec_stall_pct = 10;
					end
				endcase
			end
			if (lines_sent == RANDOM_LINES - QUIET_TAIL) quiet = 1'b1;
			make_random_line(ln);
			send_line(ln, 1'b0, ST_RECORD);
		end
		send_line(mk_line(OP_END, 1'b0, 32'h0, 32'h0, 31'h0), 1'b0, ST_RECORD);
		line_valid <= 1'b0;

		// drain, then watch for stray records
		while (expected_records.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d records checked: %0d complete, %0d awaiting more lines, %0d ignored",
			records_seen, status_seen[ST_RECORD], status_seen[ST_MORE], status_seen[ST_IGNORED]);
		$display("%0d syntax errors, %0d incomplete ends, %0d clean ends, %0d mismatches",
			status_seen[ST_SYNTAX_ERR], status_seen[ST_INCOMPLETE], status_seen[ST_END_OK],
			error_count);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* patch_code_line_decoder.f */
rtl/pcld_pkg.sv
rtl/pcld_decode.sv
rtl/patch_code_line_decoder.sv
tb/sv/testbench.sv
